// ===== rtl/kscb_pkg.sv =====
// Shared codes and field widths for the keyed substitution byte cipher.
// No dependencies; imported by keyed_substitution_byte_cipher_core.
`default_nettype none
package kscb_pkg;

  // action field codes
  localparam logic [2:0] ACT_ENCODE   = 3'd0;
  localparam logic [2:0] ACT_DECODE   = 3'd1;
  localparam logic [2:0] ACT_LOAD_KEY = 3'd2;
  localparam logic [2:0] ACT_LOAD_VEC = 3'd3;
  localparam logic [2:0] ACT_RESTART  = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEC_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MUT_INTV = 2'd2;

  localparam int unsigned KEY_LEN_W  = 9;
  localparam int unsigned VEC_LEN_W  = 6;
  localparam int unsigned MUT_INTV_W = 16;
  localparam int unsigned KEY_DEPTH  = 256;

endpackage
`default_nettype wire

// ===== rtl/keyed_substitution_byte_cipher_core.sv =====
// Keyed substitution byte cipher: top level with sequencer, maps and walk lists.
// Depends on kscb_pkg.
//
// channel  dir  handshake               payload
// in       in   in_valid_i/in_stall_o   action_i, data_byte_i, entry_index_i
// out      out  out_valid_o/out_stall_i result_byte_o
// cfg      in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// Loads finish in idle; encode runs ENC1, ENC2, FIN and decode DEC, FIN; one beat is worked on at a time.
// A reshuffle does a swap step per map entry, then rebuilds the inverse map entry by entry.
// A restart copies the start vector, links all map positions into a list, then per
// placement reduces key + 1 by repeated subtraction and walks the next-pointer memory.
// After reset a clearing pass loads the identity map; no beat taken.
// A result held by out_stall_i parks the sequencer before its state update.
`default_nettype none
module keyed_substitution_byte_cipher_core
  import kscb_pkg::*;
#(
  parameter int unsigned MAP_SIZE   = 256,
  parameter int unsigned VECTOR_MAX = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [2:0]            action_i,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic [7:0]            entry_index_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [7:0]                 result_byte_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned MW    = $clog2(MAP_SIZE);
  localparam int unsigned VW    = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1;
  localparam int unsigned RECIP = 65536 / MAP_SIZE;

  localparam logic [4:0] ST_INIT   = 5'd0;
  localparam logic [4:0] ST_IDLE   = 5'd1;
  localparam logic [4:0] ST_ENC1   = 5'd2;
  localparam logic [4:0] ST_ENC2   = 5'd3;
  localparam logic [4:0] ST_DEC    = 5'd4;
  localparam logic [4:0] ST_FIN    = 5'd5;
  localparam logic [4:0] ST_SH_RD  = 5'd6;
  localparam logic [4:0] ST_SH_J   = 5'd7;
  localparam logic [4:0] ST_SH_W1  = 5'd8;
  localparam logic [4:0] ST_SH_W2  = 5'd9;
  localparam logic [4:0] ST_INV_RD = 5'd10;
  localparam logic [4:0] ST_INV_WR = 5'd11;
  localparam logic [4:0] ST_CP_RD  = 5'd12;
  localparam logic [4:0] ST_CP_WR  = 5'd13;
  localparam logic [4:0] ST_LK     = 5'd14;
  localparam logic [4:0] ST_BK_RD  = 5'd15;
  localparam logic [4:0] ST_BK_LD  = 5'd16;
  localparam logic [4:0] ST_BK_MOD = 5'd17;
  localparam logic [4:0] ST_W_RD   = 5'd18;
  localparam logic [4:0] ST_W_UP   = 5'd19;
  localparam logic [4:0] ST_PLACE  = 5'd20;
  localparam logic [4:0] ST_LINK   = 5'd21;

  // x mod MAP_SIZE for a byte: reciprocal estimate, one correction
  function automatic logic [MW-1:0] mod_map(input logic [7:0] x);
    logic [24:0] p;
    logic [7:0]  q;
    logic [16:0] r;
    p = 25'(x) * 25'(RECIP);
    q = p[23:16];
    r = 17'(x) - 17'(q) * 17'(MAP_SIZE);
    if (r >= 17'(MAP_SIZE)) r = r - 17'(MAP_SIZE);
    return r[MW-1:0];
  endfunction

  // control and config registers
  logic [4:0]            state_q, state_d;
  logic [8:0]            k_q, k_d;
  logic [VW-1:0]         kv_q, kv_d;
  logic [7:0]            kpos_q, kpos_d;
  logic [MW-1:0]         cur_q, cur_d;
  logic [8:0]            rem_q, rem_d;
  logic [MW-1:0]         a_q, a_d, j_q, j_d, t_q, t_d;
  logic [7:0]            r_q, r_d;
  logic [2:0]            act_q, act_d;
  logic [7:0]            b_q, b_d;
  logic [VW-1:0]         vi_q, vi_d;
  logic [7:0]            prev_q, prev_d;
  logic [VW-1:0]         vidx_q, vidx_d;
  logic [15:0]           cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_q, out_d;
  logic [KEY_LEN_W-1:0]  key_len_q;
  logic [VEC_LEN_W-1:0]  vec_len_q;
  logic [MUT_INTV_W-1:0] mut_intv_q;

  // memories
  logic [MW-1:0] sm_mem [MAP_SIZE];
  logic [MW-1:0] im_mem [MAP_SIZE];
  logic [MW-1:0] nx_mem [MAP_SIZE];
  logic [MW-1:0] pv_mem [MAP_SIZE];
  logic [7:0]    key_mem [KEY_DEPTH];
  logic [7:0]    sv_mem [VECTOR_MAX];
  logic [7:0]    rv_mem [VECTOR_MAX];

  logic          sm_we, im_we, nx_we, pv_we, key_we, sv_we, rv_we;
  logic [MW-1:0] sm_wa, sm_wd, sm_ra, im_wa, im_wd, im_ra;
  logic [MW-1:0] nx_wa, nx_wd, nx_ra, pv_wa, pv_wd, pv_ra;
  logic [MW-1:0] sm_rd_q, im_rd_q, nx_rd_q, pv_rd_q;
  logic [7:0]    key_rd_q, sv_rd_q, rv_rd_q, rv_wd;
  logic [7:0]    key_ra;
  logic [VW-1:0] sv_wa, sv_ra, rv_wa, rv_ra;

  logic [8:0]    vlen, klen, dvsr, vi_nx, kv_nx;
  logic [VW-1:0] vi_cur;
  logic [15:0]   cnt_nx;
  logic [MW-1:0] j_cmb;
  logic          in_acc, fin_go, is_enc;

  always_comb begin
    if (vec_len_q == '0) vlen = 9'd1;
    else if (9'(vec_len_q) > 9'(VECTOR_MAX)) vlen = 9'(VECTOR_MAX);
    else vlen = 9'(vec_len_q);
    if (key_len_q == '0) klen = 9'd1;
    else if (key_len_q > 9'd256) klen = 9'd256;
    else klen = key_len_q;
  end

  assign vi_cur  = (9'(vidx_q) < vlen) ? vidx_q : '0;
  assign vi_nx   = 9'(vi_q) + 9'd1;
  assign kv_nx   = 9'(kv_q) + 9'd1;
  assign cnt_nx  = cnt_q + 16'd1;
  assign dvsr    = 9'(MAP_SIZE) - k_q;
  assign j_cmb   = mod_map(8'(sm_rd_q) ^ rv_rd_q);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign fin_go  = (state_q == ST_FIN) && !(out_valid_q && out_stall_i);
  assign is_enc  = (act_q == ACT_ENCODE);

  always_comb begin
    state_d = state_q;
    k_d = k_q;  kv_d = kv_q;  kpos_d = kpos_q;  cur_d = cur_q;  rem_d = rem_q;
    a_d = a_q;  j_d = j_q;  t_d = t_q;  r_d = r_q;
    act_d = act_q;  b_d = b_q;  vi_d = vi_q;
    prev_d = prev_q;  vidx_d = vidx_q;  cnt_d = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;

    sm_we = 1'b0;  sm_wa = k_q[MW-1:0];  sm_wd = k_q[MW-1:0];  sm_ra = k_q[MW-1:0];
    im_we = 1'b0;  im_wa = k_q[MW-1:0];  im_wd = k_q[MW-1:0];
    im_ra = mod_map(data_byte_i ^ prev_q);
    nx_we = 1'b0;  nx_wa = k_q[MW-1:0];  nx_wd = '0;  nx_ra = cur_q;
    pv_we = 1'b0;  pv_wa = k_q[MW-1:0];  pv_wd = '0;  pv_ra = cur_q;
    key_we = 1'b0;  key_ra = kpos_q;
    sv_we = 1'b0;  sv_wa = entry_index_i[VW-1:0];  sv_ra = k_q[VW-1:0];
    rv_we = 1'b0;  rv_wa = vi_q;  rv_wd = r_q;  rv_ra = vi_cur;

    case (state_q)
      ST_INIT: begin
        sm_we = 1'b1;
        im_we = 1'b1;
        if (k_q == 9'(MAP_SIZE - 1)) begin
          k_d = '0;
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 9'd1;
        end
      end
      ST_IDLE: begin
        act_d = action_i;
        b_d   = data_byte_i;
        vi_d  = vi_cur;
        if (in_acc) begin
          case (action_i)
            ACT_ENCODE: state_d = ST_ENC1;
            ACT_DECODE: state_d = ST_DEC;
            ACT_LOAD_KEY: key_we = 1'b1;
            ACT_LOAD_VEC: sv_we = ({1'b0, entry_index_i} < 9'(VECTOR_MAX));
            ACT_RESTART: begin
              prev_d = '0;
              vidx_d = '0;
              cnt_d = '0;
              k_d = '0;
              state_d = ST_CP_RD;
            end
            default: ;
          endcase
        end
      end
      ST_ENC1: begin
        sm_ra = mod_map(b_q ^ rv_rd_q);
        state_d = ST_ENC2;
      end
      ST_ENC2: begin
        r_d = 8'(mod_map(8'(sm_rd_q) ^ prev_q));
        state_d = ST_FIN;
      end
      ST_DEC: begin
        r_d = 8'(mod_map(8'(im_rd_q) ^ rv_rd_q));
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          out_d = r_q;
          rv_we = 1'b1;
          rv_wd = is_enc ? r_q : b_q;
          prev_d = is_enc ? b_q : r_q;
          vidx_d = (vi_nx == vlen) ? '0 : VW'(vi_nx);
          state_d = ST_IDLE;
          if (mut_intv_q != '0) begin
            if (cnt_nx == mut_intv_q) begin
              cnt_d = '0;
              k_d = '0;
              kv_d = '0;
              state_d = ST_SH_RD;
            end else begin
              cnt_d = cnt_nx;
            end
          end
        end
      end
      ST_SH_RD: begin
        rv_ra = kv_q;
        state_d = ST_SH_J;
      end
      ST_SH_J: begin
        a_d = sm_rd_q;
        j_d = j_cmb;
        sm_ra = j_cmb;
        state_d = ST_SH_W1;
      end
      ST_SH_W1: begin
        t_d = sm_rd_q;
        sm_we = 1'b1;
        sm_wa = j_q;
        sm_wd = a_q;
        state_d = ST_SH_W2;
      end
      ST_SH_W2: begin
        sm_we = 1'b1;
        sm_wd = t_q;
        kv_d = (kv_nx == vlen) ? '0 : VW'(kv_nx);
        if (k_q == 9'(MAP_SIZE - 1)) begin
          k_d = '0;
          state_d = ST_INV_RD;
        end else begin
          k_d = k_q + 9'd1;
          state_d = ST_SH_RD;
        end
      end
      ST_INV_RD: state_d = ST_INV_WR;
      ST_INV_WR: begin
        im_we = 1'b1;
        im_wa = sm_rd_q;
        if (k_q == 9'(MAP_SIZE - 1)) begin
          k_d = '0;
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 9'd1;
          state_d = ST_INV_RD;
        end
      end
      ST_CP_RD: state_d = ST_CP_WR;
      ST_CP_WR: begin
        rv_we = 1'b1;
        rv_wa = k_q[VW-1:0];
        rv_wd = sv_rd_q;
        if (k_q + 9'd1 == vlen) begin
          k_d = '0;
          state_d = ST_LK;
        end else begin
          k_d = k_q + 9'd1;
          state_d = ST_CP_RD;
        end
      end
      ST_LK: begin
        // circular doubly linked list over all map positions
        nx_we = 1'b1;
        pv_we = 1'b1;
        nx_wd = (k_q == 9'(MAP_SIZE - 1)) ? '0 : MW'(k_q + 9'd1);
        pv_wd = (k_q == 9'd0) ? MW'(MAP_SIZE - 1) : MW'(k_q - 9'd1);
        if (k_q == 9'(MAP_SIZE - 1)) begin
          k_d = '0;
          kpos_d = '0;
          cur_d = '0;
          state_d = ST_BK_RD;
        end else begin
          k_d = k_q + 9'd1;
        end
      end
      ST_BK_RD: state_d = ST_BK_LD;
      ST_BK_LD: begin
        rem_d = {1'b0, key_rd_q} + 9'd1;
        state_d = ST_BK_MOD;
      end
      ST_BK_MOD: begin
        // skip = (key + 1) mod remaining count, by repeated subtraction
        if (rem_q >= dvsr) rem_d = rem_q - dvsr;
        else state_d = ST_W_RD;
      end
      ST_W_RD: begin
        if (rem_q == '0) state_d = ST_PLACE;
        else state_d = ST_W_UP;
      end
      ST_W_UP: begin
        cur_d = nx_rd_q;
        rem_d = rem_q - 9'd1;
        state_d = ST_W_RD;
      end
      ST_PLACE: begin
        sm_we = 1'b1;
        sm_wa = cur_q;
        kpos_d = (9'(kpos_q) + 9'd1 == klen) ? '0 : kpos_q + 8'd1;
        state_d = ST_LINK;
      end
      ST_LINK: begin
        nx_we = 1'b1;
        nx_wa = pv_rd_q;
        nx_wd = nx_rd_q;
        pv_we = 1'b1;
        pv_wa = nx_rd_q;
        pv_wd = pv_rd_q;
        cur_d = nx_rd_q;
        if (k_q == 9'(MAP_SIZE - 1)) begin
          k_d = '0;
          state_d = ST_INV_RD;
        end else begin
          k_d = k_q + 9'd1;
          state_d = ST_BK_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      k_q         <= '0;
      prev_q      <= '0;
      vidx_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      key_len_q   <= KEY_LEN_W'(1);
      vec_len_q   <= VEC_LEN_W'(1);
      mut_intv_q  <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      prev_q      <= prev_d;
      vidx_q      <= vidx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY_LEN:  key_len_q  <= cfg_data_i[KEY_LEN_W-1:0];
          CFG_VEC_LEN:  vec_len_q  <= cfg_data_i[VEC_LEN_W-1:0];
          CFG_MUT_INTV: mut_intv_q <= cfg_data_i[MUT_INTV_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kv_q   <= kv_d;
    kpos_q <= kpos_d;
    cur_q  <= cur_d;
    rem_q  <= rem_d;
    a_q    <= a_d;
    j_q    <= j_d;
    t_q    <= t_d;
    r_q    <= r_d;
    act_q  <= act_d;
    b_q    <= b_d;
    vi_q   <= vi_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (sm_we) sm_mem[sm_wa] <= sm_wd;
    sm_rd_q <= sm_mem[sm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (im_we) im_mem[im_wa] <= im_wd;
    im_rd_q <= im_mem[im_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    nx_rd_q <= nx_mem[nx_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    pv_rd_q <= pv_mem[pv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[entry_index_i] <= data_byte_i;
    key_rd_q <= key_mem[key_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sv_we) sv_mem[sv_wa] <= data_byte_i;
    sv_rd_q <= sv_mem[sv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rv_we) rv_mem[rv_wa] <= rv_wd;
    rv_rd_q <= rv_mem[rv_ra];
  end

  assign out_valid_o   = out_valid_q;
  assign result_byte_o = out_q;

  // a new result only comes out of the finish step
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside finish step");

  // walk step count stays below the remaining list length
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_W_RD) |-> (rem_q < dvsr))
    else $error("walk skip not reduced");

  // reshuffle vector position stays inside the vector
  a_kv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SH_RD) |-> (9'(kv_q) < vlen))
    else $error("reshuffle vector index out of range");

  // finishing a byte returns to idle or starts a reshuffle
  a_fin_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> (state_q == ST_IDLE || state_q == ST_SH_RD))
    else $error("bad state after finish");

endmodule
`default_nettype wire

// ===== sim/keyed_substitution_byte_cipher_core_tb.sv =====
// Self-checking bench for keyed_substitution_byte_cipher_core: a clocked driver, a clocked
// monitor and a cipher predictor that tracks maps, vectors and counters per beat.
// Depends on kscb_pkg and the core RTL.
`timescale 1ns / 100ps
module keyed_substitution_byte_cipher_core_tb;
  import kscb_pkg::*;

  localparam int MSZ  = 256;
  localparam int VMAX = 32;
  localparam longint CYCLE_LIMIT = 64'd40000000;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic [7:0] entry_index;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] action_i = '0;
  logic [7:0] data_byte_i = '0;
  logic [7:0] entry_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] result_byte_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  always #2 clk_i = ~clk_i;

  keyed_substitution_byte_cipher_core dut (.*);

  // predictor state
  logic [8:0]  p_key_len = 9'd1;
  logic [5:0]  p_vec_len = 6'd1;
  logic [15:0] p_intv = '0;
  logic [7:0]  p_map [MSZ];
  logic [7:0]  p_inv [MSZ];
  logic [7:0]  p_key [256];
  logic [7:0]  p_start [VMAX];
  logic [7:0]  p_run [VMAX];
  logic [7:0]  p_last = '0;
  int          p_vi = 0;
  logic [15:0] p_ops = '0;

  beat_t       pending_beats [$];
  logic [7:0]  expected_bytes [$];
  int          errors = 0;
  int          n_results = 0;
  int          n_restarts = 0;
  longint      cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_send = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;

  function automatic int eff_klen();
    if (p_key_len == 0) return 1;
    if (p_key_len > 256) return 256;
    return p_key_len;
  endfunction

  function automatic int eff_vlen();
    if (p_vec_len == 0) return 1;
    if (p_vec_len > VMAX) return VMAX;
    return p_vec_len;
  endfunction

  function automatic void rebuild_inv();
    for (int k = 0; k < MSZ; k++) p_inv[p_map[k]] = k[7:0];
  endfunction

  function automatic void build_map();
    int nxt [MSZ];
    int prv [MSZ];
    int cur, kpos, klen, skip, nx, pv;
    cur = 0; kpos = 0; klen = eff_klen();
    for (int k = 0; k < MSZ; k++) begin
      nxt[k] = (k + 1) % MSZ;
      prv[k] = (k + MSZ - 1) % MSZ;
    end
    for (int placed = 0; placed < MSZ; placed++) begin
      skip = (int'(p_key[kpos]) + 1) % (MSZ - placed);
      for (int s = 0; s < skip; s++) cur = nxt[cur];
      kpos = (kpos + 1) % klen;
      p_map[cur] = placed[7:0];
      nx = nxt[cur]; pv = prv[cur];
      nxt[pv] = nx; prv[nx] = pv;
      cur = nx;
    end
    rebuild_inv();
  endfunction

  function automatic void reshuffle_map();
    int vlen, j;
    logic [7:0] t;
    vlen = eff_vlen();
    for (int k = 0; k < MSZ; k++) begin
      j = p_map[k] ^ p_run[k % vlen];
      t = p_map[j]; p_map[j] = p_map[k]; p_map[k] = t;
    end
    rebuild_inv();
  endfunction

  function automatic void count_op();
    if (p_intv != 0) begin
      p_ops = p_ops + 16'd1;
      if (p_ops == p_intv) begin
        reshuffle_map();
        p_ops = '0;
      end
    end
  endfunction

  function automatic void predict_cipher(beat_t b);
    int vlen, vi;
    logic [7:0] r;
    vlen = eff_vlen();
    case (b.action)
      ACT_ENCODE, ACT_DECODE: begin
        vi = (p_vi < vlen) ? p_vi : 0;
        p_vi = (vi + 1) % vlen;
        if (b.action == ACT_ENCODE) begin
          r = p_map[b.data_byte ^ p_run[vi]] ^ p_last;
          p_run[vi] = r;
          count_op();
          p_last = b.data_byte;
        end else begin
          r = p_inv[b.data_byte ^ p_last] ^ p_run[vi];
          p_run[vi] = b.data_byte;
          count_op();
          p_last = r;
        end
        expected_bytes.push_back(r);
      end
      ACT_LOAD_KEY: p_key[b.entry_index] = b.data_byte;
      ACT_LOAD_VEC: if (b.entry_index < VMAX) p_start[b.entry_index[4:0]] = b.data_byte;
      ACT_RESTART: begin
        p_last = '0; p_vi = 0; p_ops = '0;
        for (int k = 0; k < vlen; k++) p_run[k] = p_start[k];
        build_map();
        n_restarts++;
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (in_valid_i && !in_stall_o) begin
      predict_cipher(pending_beats.pop_front());
    end
    if (in_valid_i && in_stall_o) begin
      // hold the stalled beat
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid_i <= 1'b0;
    end else if (!quiet && in_valid_i && !in_stall_o && $urandom_range(0, 9) == 0) begin
      in_gap <= $urandom_range(0, 4);
      in_valid_i <= 1'b0;
    end else if (!hold_send && pending_beats.size() > 0) begin
      in_valid_i <= 1'b1;
      action_i <= pending_beats[0].action;
      data_byte_i <= pending_beats[0].data_byte;
      entry_index_i <= pending_beats[0].entry_index;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_bytes.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %02h", $time, result_byte_o);
        errors++;
      end else begin
        if (result_byte_o !== expected_bytes[0]) begin
          $display("%0t result_byte mismatch: expected %02h, actual %02h",
                   $time, expected_bytes[0], result_byte_o);
          errors++;
        end
        void'(expected_bytes.pop_front());
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      out_gap <= $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_beat(logic [2:0] a, logic [7:0] d, logic [7:0] e);
    beat_t b;
    b.action = a; b.data_byte = d; b.entry_index = e;
    pending_beats.push_back(b);
  endtask

  // wait until drained, then let a restart/reshuffle finish before touching registers
  task automatic drain_idle();
    while (pending_beats.size() > 0 || in_valid_i || expected_bytes.size() > 0)
      @(posedge clk_i);
    repeat (80000) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_KEY_LEN:  p_key_len = val[8:0];
      CFG_VEC_LEN:  p_vec_len = val[5:0];
      CFG_MUT_INTV: p_intv = val;
      default: ;
    endcase
  endtask

  // fill every key and vector entry so no unwritten entry is read
  task automatic load_all(bit rnd);
    for (int k = 0; k < 256; k++)
      push_beat(ACT_LOAD_KEY, rnd ? 8'($urandom) : 8'hFF, k[7:0]);
    for (int k = 0; k < VMAX; k++)
      push_beat(ACT_LOAD_VEC, rnd ? 8'($urandom) : 8'h00, k[7:0]);
  endtask

  task automatic random_phase(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) push_beat(ACT_ENCODE, 8'($urandom), 8'($urandom));
      else if (r < 80) push_beat(ACT_DECODE, 8'($urandom), 8'($urandom));
      else if (r < 88) push_beat(ACT_LOAD_KEY, 8'($urandom), 8'($urandom));
      else if (r < 95) push_beat(ACT_LOAD_VEC, 8'($urandom), 8'($urandom));
      else if (r < 98) push_beat(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom));
      else push_beat(ACT_RESTART, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    for (int k = 0; k < MSZ; k++) begin
      p_map[k] = k[7:0]; p_inv[k] = k[7:0];
    end
    for (int k = 0; k < 256; k++) p_key[k] = '0;
    for (int k = 0; k < VMAX; k++) begin
      p_start[k] = '0; p_run[k] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every action, ignored codes and loads
    load_all(1'b0);
    push_beat(ACT_RESTART, 8'h00, 8'h00);
    push_beat(ACT_ENCODE, 8'h00, 8'h00);
    push_beat(ACT_ENCODE, 8'hFF, 8'hFF);
    push_beat(ACT_DECODE, 8'hFF, 8'h00);
    push_beat(ACT_DECODE, 8'h00, 8'hFF);
    push_beat(ACT_LOAD_VEC, 8'hAA, 8'd32);
    push_beat(ACT_LOAD_VEC, 8'h55, 8'hFF);
    push_beat(3'd5, 8'hFF, 8'hFF);
    push_beat(3'd6, 8'h00, 8'h00);
    push_beat(3'd7, 8'h5A, 8'hA5);
    push_beat(ACT_ENCODE, 8'h5A, 8'h00);
    drain_idle();

    write_reg(CFG_KEY_LEN, 16'd256);
    write_reg(CFG_VEC_LEN, 16'd32);
    write_reg(CFG_MUT_INTV, 16'd1);
    load_all(1'b1);
    push_beat(ACT_RESTART, 8'h00, 8'h00);
    random_phase(20);
    drain_idle();

    // stale vector index after shrinking, interval lowered below counter
    write_reg(CFG_VEC_LEN, 16'd3);
    write_reg(CFG_MUT_INTV, 16'd0);
    random_phase(30);
    drain_idle();
    write_reg(CFG_MUT_INTV, 16'd40);
    random_phase(30);
    drain_idle();
    write_reg(CFG_MUT_INTV, 16'd5);
    random_phase(20);
    drain_idle();

    // out-of-range register values exercise clamping
    write_reg(CFG_KEY_LEN, 16'h01FF);
    write_reg(CFG_VEC_LEN, 16'h003F);
    write_reg(CFG_MUT_INTV, 16'hFFFF);
    push_beat(ACT_RESTART, 8'h00, 8'h00);
    random_phase(150);
    drain_idle();
    write_reg(CFG_KEY_LEN, 16'd0);
    write_reg(CFG_VEC_LEN, 16'd0);
    write_reg(CFG_MUT_INTV, 16'd17);
    push_beat(ACT_RESTART, 8'h00, 8'h00);
    random_phase(150);
    hold_send = 1'b1;
    while (expected_bytes.size() > 0) @(posedge clk_i);
    hold_send = 1'b0;
    drain_idle();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_KEY_LEN, 16'($urandom_range(1, 256)));
      write_reg(CFG_VEC_LEN, 16'($urandom_range(1, 32)));
      write_reg(CFG_MUT_INTV, 16'($urandom_range(0, 60)));
      if (ph == 3) quiet = 1'b1;
      random_phase(80);
      drain_idle();
    end

    $display("covered %0d results over %0d restarts, several register settings incl. extremes",
             n_results, n_restarts);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
